/* rtl/tmt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tmt_pkg;

    // Fixed field widths
    localparam int SCORE_BITS = 16;
    localparam int PASS_BITS  = 8;

    // Defaults for top-level parameters and registers
    localparam int                   MAX_ITEMS_DEF  = 2048;
    localparam logic [PASS_BITS-1:0] PASS_COUNT_RST = 8'd100;

    typedef struct packed {
        logic [SCORE_BITS-1:0] score;
        logic                  absent;
        logic                  last;
    } t_in_item;

    typedef struct packed {
        logic [SCORE_BITS-1:0] threshold;
        logic                  high_empty;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_PREP,
        ST_SCAN,
        ST_DIV_HI,
        ST_WAIT_HI,
        ST_DIV_LO,
        ST_WAIT_LO,
        ST_NEXT,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

/* rtl/two_means_threshold.sv */
// Loading: one request per cycle while ready; ready is low while clustering or emitting.
// Clustering, after the request marked last, runs P passes over the N stored items; its time is
//   set by the single score-store read port (one item per cycle in the scan) and the shared
//   one-bit-per-cycle divider on SW = 16 + clog2(MAX_ITEMS+1) bits (up to two means a pass).
// Result is registered in the emit state once any earlier result is taken, and held until taken.
// Reset (i_rst_n low at a rising edge) clears control and counters; pass_count returns to 100.
`timescale 1ns / 1ps
`default_nettype none

module two_means_threshold #(
    parameter int MAX_ITEMS = tmt_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [tmt_pkg::PASS_BITS-1:0]    i_cfg_wdata,
    // Input requests
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire tmt_pkg::t_in_item                i_in,
    // Results
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output tmt_pkg::t_out_item                    o_out
);

    import tmt_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = SCORE_BITS + CW;
    localparam int EW = SCORE_BITS + 1;

    localparam logic [CW-1:0]         MAX_CNT    = CW'(MAX_ITEMS);
    localparam logic [SCORE_BITS-1:0] SCORE_ONES = '1;

    // Sequencer
    t_state r_state, n_state;

    // Loaded data set
    logic [PASS_BITS-1:0]  r_pass_count;
    logic [CW-1:0]         r_total;
    logic [SCORE_BITS-1:0] r_max;

    // Clustering state
    logic [SCORE_BITS-1:0] r_hc;
    logic [SCORE_BITS-1:0] r_lc;
    logic [SW-1:0]         r_hsum;
    logic [SW-1:0]         r_lsum;
    logic [CW-1:0]         r_hmem;
    logic [CW-1:0]         r_lmem;
    logic [SCORE_BITS-1:0] r_hmin;
    logic [PASS_BITS-1:0]  r_pass;
    logic [CW-1:0]         r_idx;
    logic                  r_rd_valid;

    // Result register
    logic                  r_out_valid;
    t_out_item             r_out;

    // Control decoded from the state
    logic                  w_in_ready;
    logic                  w_in_acc;
    logic                  w_store;
    logic                  w_rd_en;
    logic                  w_div_start;
    logic                  w_emit;
    logic [SW-1:0]         w_div_num;
    logic [CW-1:0]         w_div_den;
    logic                  w_div_done;
    logic [SW-1:0]         w_div_quo;

    // Score read back from the store
    logic [EW-1:0]         w_rdata;
    logic [SCORE_BITS-1:0] w_x;
    logic                  w_x_absent;
    logic [SCORE_BITS-1:0] w_dh;
    logic [SCORE_BITS-1:0] w_dl;
    logic                  w_to_low;

    // -------------------------------------------------------------------------
    // Next state
    // -------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc && i_in.last) n_state = ST_INIT;
            end
            ST_INIT: begin
                // A pass count of zero runs no pass and reports an empty high group
                n_state = (r_pass_count == '0) ? ST_EMIT : ST_PREP;
            end
            ST_PREP: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if ((r_idx == r_total) && !r_rd_valid) n_state = ST_DIV_HI;
            end
            ST_DIV_HI: begin
                // An empty group keeps its centre, so skip its division
                n_state = (r_hmem != '0) ? ST_WAIT_HI : ST_DIV_LO;
            end
            ST_WAIT_HI: begin
                if (w_div_done) n_state = ST_DIV_LO;
            end
            ST_DIV_LO: begin
                n_state = (r_lmem != '0) ? ST_WAIT_LO : ST_NEXT;
            end
            ST_WAIT_LO: begin
                if (w_div_done) n_state = ST_NEXT;
            end
            ST_NEXT: begin
                n_state = ((r_pass + 1'b1) < r_pass_count) ? ST_PREP : ST_EMIT;
            end
            ST_EMIT: begin
                // Hold here while an earlier result still waits to be taken
                if (!r_out_valid || i_out_ready) n_state = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // -------------------------------------------------------------------------
    // Control outputs
    // -------------------------------------------------------------------------
    always_comb begin
        w_in_ready  = 1'b0;
        w_rd_en     = 1'b0;
        w_div_start = 1'b0;
        w_emit      = 1'b0;
        w_div_num   = r_hsum;
        w_div_den   = r_hmem;
        case (r_state)
            ST_LOAD: begin
                w_in_ready = 1'b1;
            end
            ST_SCAN: begin
                w_rd_en = (r_idx != r_total);
            end
            ST_DIV_HI: begin
                w_div_start = (r_hmem != '0);
            end
            ST_DIV_LO: begin
                w_div_start = (r_lmem != '0);
                w_div_num   = r_lsum;
                w_div_den   = r_lmem;
            end
            ST_EMIT: begin
                w_emit = !r_out_valid || i_out_ready;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    assign w_in_acc = i_in_valid && w_in_ready;
    // Drop requests beyond a full store; a last mark on them still counts
    assign w_store  = w_in_acc && (r_total != MAX_CNT);

    // -------------------------------------------------------------------------
    // Score store
    // -------------------------------------------------------------------------
    tmt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_total[AW-1:0]),
        .i_wdata ({i_in.absent, i_in.score}),
        .i_re    (w_rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_x_absent = w_rdata[EW-1];
    assign w_x        = w_rdata[SCORE_BITS-1:0];

    // Nearer centre; a tie goes to the high group
    assign w_dh     = (r_hc >= w_x) ? (r_hc - w_x) : (w_x - r_hc);
    assign w_dl     = (w_x >= r_lc) ? (w_x - r_lc) : (r_lc - w_x);
    assign w_to_low = (w_dh > w_dl);

    // -------------------------------------------------------------------------
    // Shared divider for both centre updates
    // -------------------------------------------------------------------------
    tmt_div #(
        .NUM_W (SW),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // -------------------------------------------------------------------------
    // Registers
    // -------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_pass_count <= PASS_COUNT_RST;
            r_total      <= '0;
            r_max        <= '0;
            r_hc         <= '0;
            r_lc         <= '0;
            r_hsum       <= '0;
            r_lsum       <= '0;
            r_hmem       <= '0;
            r_lmem       <= '0;
            r_hmin       <= SCORE_ONES;
            r_pass       <= '0;
            r_idx        <= '0;
            r_rd_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_pass_count <= i_cfg_wdata;
            end

            // Load: count the request and track the largest present score
            if (w_store) begin
                r_total <= r_total + 1'b1;
                if (!i_in.absent && (i_in.score > r_max)) begin
                    r_max <= i_in.score;
                end
            end

            // Seed the centres from the maximum
            if (r_state == ST_INIT) begin
                r_hc   <= r_max;
                r_lc   <= r_max >> 1;
                r_hmem <= '0;
                r_hmin <= SCORE_ONES;
                r_pass <= '0;
            end

            // Clear the accumulators before each pass
            if (r_state == ST_PREP) begin
                r_hsum     <= '0;
                r_lsum     <= '0;
                r_hmem     <= '0;
                r_lmem     <= '0;
                r_hmin     <= SCORE_ONES;
                r_idx      <= '0;
                r_rd_valid <= 1'b0;
            end

            // Scan: issue one read a cycle, classify the score read last cycle
            if (r_state == ST_SCAN) begin
                if (w_rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_rd_valid <= w_rd_en;
                if (r_rd_valid && !w_x_absent) begin
                    if (w_to_low) begin
                        r_lsum <= r_lsum + SW'(w_x);
                        r_lmem <= r_lmem + 1'b1;
                    end else begin
                        r_hsum <= r_hsum + SW'(w_x);
                        r_hmem <= r_hmem + 1'b1;
                        if (w_x < r_hmin) begin
                            r_hmin <= w_x;
                        end
                    end
                end
            end

            // Move the centres to the truncated means
            if ((r_state == ST_WAIT_HI) && w_div_done) begin
                r_hc <= w_div_quo[SCORE_BITS-1:0];
            end
            if ((r_state == ST_WAIT_LO) && w_div_done) begin
                r_lc <= w_div_quo[SCORE_BITS-1:0];
            end

            if (r_state == ST_NEXT) begin
                r_pass <= r_pass + 1'b1;
            end

            // A new result overrides; otherwise drop the result once taken
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_total     <= '0;
                r_max       <= '0;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (r_hmem != '0) begin
                r_out.threshold  <= r_hmin;
                r_out.high_empty <= 1'b0;
            end else begin
                r_out.threshold  <= SCORE_ONES;
                r_out.high_empty <= 1'b1;
            end
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

/* rtl/tmt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tmt_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/tmt_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tmt_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_rem_sh;
    logic             w_ge;
    logic [DEN_W:0]   w_rem_nx;

    assign w_rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_rem_nx[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

/* rtl/tmt_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module tmt_chk (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_ready,
    input  wire tmt_pkg::t_in_item             i_in,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire tmt_pkg::t_out_item            o_out
);

    import tmt_pkg::*;

    localparam logic [SCORE_BITS-1:0] SCORE_ONES = '1;

    // A request marked last starts clustering: no request is taken next cycle
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.last) |=> !o_in_ready)
        else $error("request taken right after a last request");

    // A result only appears as clustering ends, never while loading
    a_rose_after_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a clustering run");

    // An empty high group reports an all-ones threshold
    a_empty_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.high_empty) |-> (o_out.threshold == SCORE_ONES))
        else $error("empty high group with a threshold other than all ones");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed or dropped");

endmodule

bind two_means_threshold tmt_chk u_tmt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import tmt_pkg::*;

    localparam int          STORE_DEPTH = MAX_ITEMS_DEF;
    localparam int unsigned CYCLE_LIMIT = 20_000_000;

    // One row of the directed part: optional pass-count write ahead of the request,
    // the request itself, and a hand-typed result where it is obvious.
    typedef struct packed {
        bit                  set_passes;
        bit [PASS_BITS-1:0]  passes;
        bit [SCORE_BITS-1:0] score;
        bit                  absent;
        bit                  last;
        bit                  typed;
        bit [SCORE_BITS-1:0] thr;
        bit                  empty;
    } t_row;

    localparam int DIRECTED_ROWS = 20;
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        // after reset, 100 passes: single present score is its own threshold
        '{1'b0, 8'd0,   16'h0000, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b0},
        '{1'b0, 8'd0,   16'hFFFF, 1'b0, 1'b1, 1'b1, 16'hFFFF, 1'b0},
        // no present score at all
        '{1'b0, 8'd0,   16'h1234, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1},
        // one pass, extremes split apart
        '{1'b1, 8'd1,   16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 8'd0,   16'hFFFF, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
        // absent large score must not become the maximum
        '{1'b0, 8'd0,   16'd100,  1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 8'd0,   16'd200,  1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 8'd0,   16'hC350, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 8'd0,   16'd300,  1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
        // most passes
        '{1'b1, 8'd255, 16'h8000, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 8'd0,   16'h7FFF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 8'd0,   16'h0001, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 8'd0,   16'hFFFE, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
        // equal scores: ties go high, low group stays empty
        '{1'b0, 8'd0,   16'h04D2, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 8'd0,   16'h04D2, 1'b0, 1'b1, 1'b1, 16'h04D2, 1'b0},
        // zero passes: always the empty result
        '{1'b1, 8'd0,   16'h01F4, 1'b0, 1'b1, 1'b1, 16'hFFFF, 1'b1},
        // back to the reset value, alternating bit patterns, absent last
        '{1'b1, 8'd100, 16'hAAAA, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 8'd0,   16'h5555, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 8'd0,   16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 8'd0,   16'hFFFF, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0}
    };

    // Random segments: pass-count range and rough request count per segment
    localparam int SEGMENTS = 9;
    localparam int SEG_LO  [SEGMENTS] = '{1, 255, 5,  2, 100, 1,  0, 3,  1};
    localparam int SEG_HI  [SEGMENTS] = '{1, 255, 20, 2, 100, 20, 0, 40, 1};
    localparam int SEG_LEN [SEGMENTS] = '{300, 60, 220, 300, 80, 200, 40, 260, 300};
    localparam bit [SCORE_BITS-1:0] CORNER_SCORES [6] =
        '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [PASS_BITS-1:0] cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_req    = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_res;

    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    // Shadow of the block: stored scores, running maximum and pass count
    bit [SCORE_BITS-1:0] held_score  [STORE_DEPTH];
    bit                  held_absent [STORE_DEPTH];
    int unsigned         held_count = 0;
    bit [SCORE_BITS-1:0] held_peak  = '0;
    bit [PASS_BITS-1:0]  pass_setting = PASS_COUNT_RST;
    t_out_item           pending_thresholds [$];

    two_means_threshold uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Two-means clustering over the held scores with the current pass count
    function automatic t_out_item cluster_threshold();
        bit [SCORE_BITS-1:0] hi_c, lo_c, hi_min, x, d_hi, d_lo;
        bit [26:0]           hi_sum, lo_sum;
        int unsigned         hi_n, lo_n, p, i;
        t_out_item           res;
        hi_c   = held_peak;
        lo_c   = held_peak >> 1;
        hi_n   = 0;
        hi_min = '1;
        for (p = 0; p < pass_setting; p++) begin
            hi_sum = '0;
            lo_sum = '0;
            hi_n   = 0;
            lo_n   = 0;
            hi_min = '1;
            for (i = 0; i < held_count; i++) begin
                if (!held_absent[i]) begin
                    x    = held_score[i];
                    d_hi = (hi_c >= x) ? hi_c - x : x - hi_c;
                    d_lo = (x >= lo_c) ? x - lo_c : lo_c - x;
                    if (d_hi > d_lo) begin
                        lo_sum += x;
                        lo_n++;
                    end else begin
                        hi_sum += x;
                        hi_n++;
                        if (x < hi_min)
                            hi_min = x;
                    end
                end
            end
            if (hi_n != 0)
                hi_c = SCORE_BITS'(hi_sum / hi_n);
            if (lo_n != 0)
                lo_c = SCORE_BITS'(lo_sum / lo_n);
        end
        res.threshold  = (hi_n != 0) ? hi_min : '1;
        res.high_empty = (hi_n == 0);
        return res;
    endfunction

    // Offer one request, idling first at random; update the shadow once it is taken
    task automatic send_request(input t_in_item req, input bit typed, input t_out_item typed_res);
        t_out_item res;
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (held_count < STORE_DEPTH) begin
            held_score[held_count]  = req.score;
            held_absent[held_count] = req.absent;
            held_count++;
            if (!req.absent && req.score > held_peak)
                held_peak = req.score;
        end
        if (req.last) begin
            res = typed ? typed_res : cluster_threshold();
            pending_thresholds.push_back(res);
            held_count = 0;
            held_peak  = '0;
        end
    endtask

    // Drop valid and hold until every expected threshold has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_thresholds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_passes(input bit [PASS_BITS-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        pass_setting  = value;
    endtask

    // One data set: half the time two clusters with spread, otherwise flat random,
    // corner values or largely absent
    task automatic send_set(input int unsigned size);
        int unsigned k, kind, spread;
        int          c_lo, c_hi, v;
        t_in_item    req;
        kind   = $urandom_range(0, 7);
        c_lo   = $urandom_range(0, 65535);
        c_hi   = $urandom_range(0, 65535);
        spread = 1 << $urandom_range(0, 14);
        for (k = 0; k < size; k++) begin
            if (kind <= 3) begin
                v = ($urandom_range(0, 1) ? c_lo : c_hi) + $urandom_range(0, spread);
                if (v > 65535)
                    v = 65535;
            end else if (kind == 6) begin
                v = CORNER_SCORES[$urandom_range(0, 5)];
            end else begin
                v = $urandom_range(0, 65535);
            end
            req.score  = SCORE_BITS'(v);
            req.absent = (kind == 7) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
            req.last   = (k == size - 1);
            send_request(req, 1'b0, '0);
        end
    endtask

    // Result side: check against the oldest expectation, then stall at random
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (pending_thresholds.size() == 0) begin
                    $error("threshold: unexpected result %h (empty %b)",
                           out_res.threshold, out_res.high_empty);
                    mismatches++;
                end else begin
                    if (out_res.threshold !== pending_thresholds[0].threshold) begin
                        $error("threshold: expected %h, got %h",
                               pending_thresholds[0].threshold, out_res.threshold);
                        mismatches++;
                    end
                    if (out_res.high_empty !== pending_thresholds[0].high_empty) begin
                        $error("high_empty: expected %b, got %b",
                               pending_thresholds[0].high_empty, out_res.high_empty);
                        mismatches++;
                    end
                    void'(pending_thresholds.pop_front());
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial begin
        int unsigned r, s, sent, size;
        t_in_item    req;
        t_out_item   typed_res;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 32;
        recv_idle = 84;

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            if (DIRECTED[r].set_passes)
                write_passes(DIRECTED[r].passes);
            req.score            = DIRECTED[r].score;
            req.absent           = DIRECTED[r].absent;
            req.last             = DIRECTED[r].last;
            typed_res.threshold  = DIRECTED[r].thr;
            typed_res.high_empty = DIRECTED[r].empty;
            send_request(req, DIRECTED[r].typed, typed_res);
        end

        for (s = 0; s < SEGMENTS; s++) begin
            if (s == 3) begin
                send_idle = 84;
                recv_idle = 32;
            end else if (s == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_passes(PASS_BITS'($urandom_range(SEG_LO[s], SEG_HI[s])));
            sent = 0;
            while (sent < SEG_LEN[s]) begin
                size = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                                   : $urandom_range(1, 12);
                send_set(size);
                sent += size;
                if ($urandom_range(0, 11) == 0)
                    settle();
            end
        end

        settle();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
rtl/tmt_pkg.sv
rtl/tmt_ram.sv
rtl/tmt_div.sv
rtl/two_means_threshold.sv
rtl/tmt_chk.sv
sim/tb.sv
